>>> hw/rtl/etok_pkg.sv
// Shared types and constants of the expression tokenizer.
// Used by the front end, the token queue, the back end and the checker.
package etok_pkg;

  localparam int MAX_EXPR_LEN = 4096;
  localparam int POS_W        = $clog2(MAX_EXPR_LEN + 1);
  localparam int START_W      = $clog2(MAX_EXPR_LEN);

  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_NUM   = 3'd0,
    KIND_OP    = 3'd1,
    KIND_VAR   = 3'd2,
    KIND_FUNC  = 3'd3,
    KIND_OPEN  = 3'd4,
    KIND_CLOSE = 3'd5,
    KIND_END   = 3'd6,
    KIND_ERR   = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [START_W-1:0]  start_pos;
    logic [POS_W-1:0]    length;
    logic [7:0]          symbol;
  } tok_t;

  // One queue entry holds every token caused by one character.
  typedef struct packed {
    tok_t first;
    tok_t second;
    logic has_second;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

>>> hw/rtl/etok_front.sv
// Front end: accepts characters, classifies them, tracks the scan state
// and pushes the tokens of each character into the queue. Uses etok_pkg.
module etok_front import etok_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  fifo_stat_t fifo_stat,
  output logic       push,
  output entry_t     push_entry
);

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_NUM  = 3'b010,
    MODE_NAME = 3'b100
  } mode_t;

  mode_t              mode, mode_next;
  logic [START_W-1:0] token_start, token_start_next;
  logic [POS_W-1:0]   position, position_next;
  logic               discarding, discarding_next;

  logic               accept;
  logic               pos_sat;
  logic [POS_W-1:0]   pos_adv;
  logic [START_W-1:0] here;
  logic [POS_W-1:0]   run_len;
  logic               pend_emit, fresh_emit;
  tok_t               pend_tok, fresh_tok;

  function automatic logic is_dec_digit(input logic [7:0] c);
    is_dec_digit = (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    is_term = (c < 8'h20) || (c == 8'h7f);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    is_op = (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
            (c == "^") || (c == "!");
  endfunction

  assign in_ready = !fifo_stat.full;
  assign accept   = in_valid && in_ready;

  assign pos_sat = (position == POS_W'(MAX_EXPR_LEN));
  assign pos_adv = pos_sat ? position : position + 1'b1;
  assign here    = pos_sat ? START_W'(MAX_EXPR_LEN - 1) : position[START_W-1:0];
  assign run_len = position - POS_W'(token_start);

  always_comb begin
    mode_next        = mode;
    token_start_next = token_start;
    position_next    = position;
    discarding_next  = discarding;
    pend_emit        = 1'b0;
    fresh_emit       = 1'b0;
    pend_tok         = '{kind: KIND_NUM, start_pos: token_start, length: run_len,
                         symbol: 8'h00};
    fresh_tok        = '{kind: KIND_END, start_pos: here, length: '0, symbol: 8'h00};

    if (discarding) begin
      if (is_term(ch)) begin
        discarding_next  = 1'b0;
        mode_next        = MODE_IDLE;
        position_next    = '0;
        token_start_next = '0;
      end
    end else if ((mode == MODE_NUM) && (is_dec_digit(ch) || ch == ".")) begin
      position_next = pos_adv;
    end else if ((mode == MODE_NAME) &&
                 (is_letter(ch) || is_dec_digit(ch) || ch == "_")) begin
      position_next = pos_adv;
    end else begin
      // Close the pending token, then treat the character as a fresh one.
      unique case (mode)
        MODE_NUM: begin
          pend_emit     = 1'b1;
          pend_tok.kind = KIND_NUM;
        end
        MODE_NAME: begin
          pend_emit     = 1'b1;
          pend_tok.kind = (ch == "(") ? KIND_FUNC : KIND_VAR;
        end
        default: pend_emit = 1'b0;
      endcase
      mode_next = MODE_IDLE;

      priority if (is_term(ch)) begin
        fresh_emit       = 1'b1;
        fresh_tok.kind   = KIND_END;
        position_next    = '0;
        token_start_next = '0;
      end else if (ch == " ") begin
        position_next = pos_adv;
      end else if (is_dec_digit(ch) || ch == ".") begin
        token_start_next = here;
        mode_next        = MODE_NUM;
        position_next    = pos_adv;
      end else if (is_op(ch)) begin
        fresh_emit       = 1'b1;
        fresh_tok.kind   = KIND_OP;
        fresh_tok.length = POS_W'(1);
        fresh_tok.symbol = ch;
        position_next    = pos_adv;
      end else if (is_letter(ch) || ch == "_") begin
        token_start_next = here;
        mode_next        = MODE_NAME;
        position_next    = pos_adv;
      end else if (ch == "(" || ch == ")") begin
        fresh_emit       = 1'b1;
        fresh_tok.kind   = (ch == "(") ? KIND_OPEN : KIND_CLOSE;
        fresh_tok.length = POS_W'(1);
        fresh_tok.symbol = ch;
        position_next    = pos_adv;
      end else begin
        fresh_emit      = 1'b1;
        fresh_tok.kind  = KIND_ERR;
        discarding_next = 1'b1;
      end
    end
  end

  always_comb begin
    if (pend_emit) begin
      push_entry.first      = pend_tok;
      push_entry.second     = fresh_tok;
      push_entry.has_second = fresh_emit;
    end else begin
      push_entry.first      = fresh_tok;
      push_entry.second     = fresh_tok;
      push_entry.has_second = 1'b0;
    end
  end

  assign push = accept && (pend_emit || fresh_emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      token_start <= '0;
      position    <= '0;
      discarding  <= 1'b0;
    end else if (accept) begin
      mode        <= mode_next;
      token_start <= token_start_next;
      position    <= position_next;
      discarding  <= discarding_next;
    end
  end

endmodule

>>> hw/rtl/etok_fifo.sv
// Short token queue between front end and back end, held in flip-flops.
// Uses etok_pkg for the entry type and depth.
module etok_fifo import etok_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  entry_t     push_entry,
  input  logic       pop,
  output entry_t     head,
  output fifo_stat_t stat
);

  entry_t                 slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0]  count;
  logic                   do_push, do_pop;

  assign stat.full  = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slots[rd_ptr];

  function automatic logic [FIFO_PTR_W-1:0] bump(input logic [FIFO_PTR_W-1:0] p);
    bump = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/etok_back.sv
// Back end: takes queue entries and sends their tokens one per transfer
// from an output register, marking the final one. Uses etok_pkg.
module etok_back import etok_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  fifo_stat_t fifo_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output tok_t       out_tok,
  output logic       out_last
);

  logic load;
  logic pend_valid;
  tok_t pend_tok;

  // The output register may take a new token when empty or being drained.
  assign load = !out_valid || out_ready;
  assign pop  = load && !pend_valid && !fifo_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        out_valid  <= !fifo_stat.empty;
        pend_valid <= !fifo_stat.empty && head.has_second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        out_tok  <= pend_tok;
        out_last <= 1'b1;
      end else begin
        out_tok  <= head.first;
        out_last <= !head.has_second;
        pend_tok <= head.second;
      end
    end
  end

endmodule

>>> hw/rtl/expression_tokenizer_core.sv
// Expression tokenizer: one character in per transfer, tokens out.
// Built from etok_front, etok_fifo and etok_back; uses etok_pkg.
//
// One character is accepted every cycle while the token queue is not
// full. Each character yields zero, one or two tokens (kind, start_pos,
// length, symbol, last); the output register sends one token per cycle
// while out_ready is high, so a character that both closes a number or
// name and makes its own token sends two tokens in turn. A four-entry
// token queue between the character classifier and the output stage
// absorbs those bursts; input stalls only when it fills, so sustained
// input rate is one character per cycle as long as at most one token per
// character is produced on average and out_ready stays high.
module expression_tokenizer_core import etok_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          ch,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          kind,
  output logic [START_W-1:0]  start_pos,
  output logic [POS_W-1:0]    length,
  output logic [7:0]          symbol,
  output logic                last
);

  fifo_stat_t fifo_stat;
  logic       push, pop;
  entry_t     push_entry, head;
  tok_t       out_tok;

  etok_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .fifo_stat  (fifo_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  etok_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (fifo_stat)
  );

  etok_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .fifo_stat (fifo_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (out_tok),
    .out_last  (last)
  );

  assign kind      = out_tok.kind;
  assign start_pos = out_tok.start_pos;
  assign length    = out_tok.length;
  assign symbol    = out_tok.symbol;

endmodule

>>> hw/rtl/etok_checker.sv
// Port-level checks of the expression tokenizer and the bind that
// attaches them to expression_tokenizer_core. Uses etok_pkg.
module etok_checker import etok_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [2:0]          kind,
  input logic [START_W-1:0]  start_pos,
  input logic [POS_W-1:0]    length,
  input logic [7:0]          symbol,
  input logic                last
);

  // Hold a stalled token until its transfer.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(start_pos) &&
      $stable(length) && $stable(symbol) && $stable(last))
    else $error("stalled token changed");

  // End and error markers carry nothing and always close a character's tokens.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_END || kind == KIND_ERR) |->
      length == '0 && symbol == 8'h00 && last)
    else $error("malformed end or error marker");

  // Single-character tokens carry their symbol.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_OP || kind == KIND_OPEN || kind == KIND_CLOSE) |->
      length == POS_W'(1) && symbol != 8'h00)
    else $error("malformed operator or parenthesis token");

  // Runs are never empty and have no symbol.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_NUM || kind == KIND_VAR || kind == KIND_FUNC) |->
      length != '0 && symbol == 8'h00)
    else $error("malformed number or name token");

endmodule

bind expression_tokenizer_core etok_checker u_etok_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .start_pos (start_pos),
  .length    (length),
  .symbol    (symbol),
  .last      (last)
);
